### rtl/slint_pkg.sv
// ----------------------------------------------------------------------------
// slint_pkg: shared types and constants
// Request and result layouts, command codes and sizes for the sorted list
// intersection unit.
// ----------------------------------------------------------------------------
package slint_pkg;

  // list storage size and derived widths
  localparam int DEPTH = 64;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  // request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // command codes on the request port
  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_START  = 2'd2;

  // classified operation kinds in the request queue
  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
    logic        same_list;
  } req_t;

  typedef struct packed {
    logic [31:0] element;
    logic        empty_res;
    logic        found;
    logic        overflow;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        same_list;
  } op_t;

  // queue head toward the back part
  typedef struct packed {
    logic avail;
    op_t  op;
  } op_head_t;

  // result push toward the output queue
  typedef struct packed {
    logic push;
    res_t item;
  } res_push_t;

endpackage

### rtl/slint_front.sv
// ----------------------------------------------------------------------------
// slint_front: request intake and queue
// Accepts requests, drops unused command codes and queues classified
// operations for the back part.
// ----------------------------------------------------------------------------
module slint_front import slint_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  req_t     req,
  output op_head_t head,
  input  logic     head_pop
);

  op_t            q [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           accept;
  logic           keep;
  logic           wr_en;
  logic           rd_en;
  op_t            op_in;

  // classify the incoming request
  always_comb begin
    op_in.value     = req.value;
    op_in.same_list = req.same_list;
    op_in.kind      = KIND_LOAD_A;
    keep            = 1'b1;
    unique case (req.cmd)
      CMD_LOAD_A: op_in.kind = KIND_LOAD_A;
      CMD_LOAD_B: op_in.kind = KIND_LOAD_B;
      CMD_START:  op_in.kind = KIND_START;
      default:    keep       = 1'b0;
    endcase
  end

  assign full   = (count == QCW'(QDEPTH));
  assign accept = push && !full;
  assign wr_en  = accept && keep;
  assign rd_en  = head_pop && (count != '0);

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= op_in;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCW'(wr_en) - QCW'(rd_en);
    end
  end

  assign head.avail = (count != '0);
  assign head.op    = q[rd_ptr];

endmodule

### rtl/slint_back.sv
// ----------------------------------------------------------------------------
// slint_back: list storage and merge walk
// Executes loads into both list memories and runs the merge walk for a start,
// one compare step per cycle; a full output queue for results can stall it.
// ----------------------------------------------------------------------------
module slint_back import slint_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_wdata,
  input  op_head_t  head,
  output logic      head_pop,
  output res_push_t rp,
  input  logic      oq_full
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [31:0]   mem_a [DEPTH];
  logic [31:0]   mem_b [DEPTH];
  logic [31:0]   rd_a;
  logic [31:0]   rd_b;
  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;
  logic          overflow_seen;
  logic          report_mode;
  logic          same;
  logic          hit;
  logic          pend_v;
  logic [31:0]   pend;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] i_next;
  logic [CW-1:0] j_next;
  logic          start;
  logic          load_a;
  logic          load_b;
  logic          walk_done;
  logic          match;
  logic          adv_i;
  logic          adv_j;
  logic          take;
  logic          set_hit;
  logic          finish;

  // pop one operation whenever idle
  assign head_pop = (state == ST_IDLE) && head.avail;
  assign start    = head_pop && (head.op.kind == KIND_START);
  assign load_a   = head_pop && (head.op.kind == KIND_LOAD_A);
  assign load_b   = head_pop && (head.op.kind == KIND_LOAD_B);

  // one merge step from the current pair of elements
  assign walk_done = (i >= count_a) || (!same && (j >= count_b));
  assign match     = same || (rd_a == rd_b);

  always_comb begin
    state_next = state;
    adv_i      = 1'b0;
    adv_j      = 1'b0;
    take       = 1'b0;
    set_hit    = 1'b0;
    finish     = 1'b0;
    rp.push    = 1'b0;
    rp.item    = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        priority if (walk_done) begin
          state_next = ST_FINAL;
        end else if (match) begin
          if (report_mode) begin
            set_hit    = 1'b1;
            state_next = ST_FINAL;
          end else if (!(pend_v && oq_full)) begin
            // previous match is not the last one
            rp.push         = pend_v;
            rp.item.element = pend;
            rp.item.overflow = overflow_seen;
            take            = 1'b1;
            adv_i           = 1'b1;
            adv_j           = !same;
          end
        end else if (rd_a < rd_b) begin
          adv_i = 1'b1;
        end else begin
          adv_j = 1'b1;
        end
      end
      ST_FINAL: begin
        if (!oq_full) begin
          rp.push          = 1'b1;
          rp.item.overflow = overflow_seen;
          rp.item.last     = 1'b1;
          if (report_mode) begin
            rp.item.found = hit;
          end else if (pend_v) begin
            rp.item.element = pend;
          end else begin
            rp.item.empty_res = 1'b1;
          end
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign i_next = start ? '0 : i + CW'(adv_i);
  assign j_next = start ? '0 : j + CW'(adv_j);

  // list memories, read at the next walk position
  always_ff @(posedge clk) begin
    if (load_a && (count_a < CW'(DEPTH))) begin
      mem_a[count_a[AW-1:0]] <= head.op.value;
    end
    if (load_b && (count_b < CW'(DEPTH))) begin
      mem_b[count_b[AW-1:0]] <= head.op.value;
    end
    rd_a <= mem_a[i_next[AW-1:0]];
    rd_b <= mem_b[j_next[AW-1:0]];
  end

  // pending match held until the next one or the end of the walk
  always_ff @(posedge clk) begin
    if (take) begin
      pend <= rd_a;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count_a       <= '0;
      count_b       <= '0;
      overflow_seen <= 1'b0;
      report_mode   <= 1'b0;
      same          <= 1'b0;
      hit           <= 1'b0;
      pend_v        <= 1'b0;
      i             <= '0;
      j             <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      if (cfg_we) begin
        report_mode <= cfg_wdata;
      end
      if (load_a) begin
        if (count_a < CW'(DEPTH)) begin
          count_a <= count_a + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (load_b) begin
        if (count_b < CW'(DEPTH)) begin
          count_b <= count_b + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (start) begin
        same   <= head.op.same_list && !report_mode;
        hit    <= 1'b0;
        pend_v <= 1'b0;
      end
      if (take) begin
        pend_v <= 1'b1;
      end
      if (set_hit) begin
        hit <= 1'b1;
      end
      if (finish) begin
        count_a       <= '0;
        count_b       <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

endmodule

### rtl/slint_outq.sv
// ----------------------------------------------------------------------------
// slint_outq: result queue
// Holds finished results until the consumer pops them, so the merge walk
// keeps going while a result waits.
// ----------------------------------------------------------------------------
module slint_outq import slint_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  res_push_t rp,
  output logic      oq_full,
  output logic      empty,
  input  logic      pop,
  output res_t      res
);

  res_t           q [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           wr_en;
  logic           rd_en;

  assign oq_full = (count == QCW'(QDEPTH));
  assign empty   = (count == '0);
  assign wr_en   = rp.push && !oq_full;
  assign rd_en   = pop && !empty;

  // result storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q[wr_ptr] <= rp.item;
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QAW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QAW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCW'(wr_en) - QCW'(rd_en);
    end
  end

  assign res = q[rd_ptr];

endmodule

### rtl/sorted_list_intersection_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_intersection_unit: merge intersection of two sorted lists
// Loads two ascending lists and, on start, emits their common elements or
// reports whether any exists.
//
//   channel   handshake         payload
//   request   push / full       req   (cmd, value, same_list)
//   result    pop / empty       res   (element, empty_res, found, overflow, last)
//   config    cfg_we            cfg_wdata (report_mode)
//
// Requests enter a 4-entry queue at one per cycle while it is not full; a
// load completes as the back part pops it. On a start, the merge walk does
// one compare per cycle on registered memory reads. Results wait in a
// 4-entry output queue; when it fills, the walk holds.
// Reset is synchronous; list memories are not cleared, the counts are.
// ----------------------------------------------------------------------------
module sorted_list_intersection_unit import slint_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t req,
  output logic empty,
  input  logic pop,
  output res_t res,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  op_head_t  head;
  logic      head_pop;
  res_push_t rp;
  logic      oq_full;

  // request intake
  slint_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .req      (req),
    .head     (head),
    .head_pop (head_pop)
  );

  // loads and merge walk
  slint_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .head_pop  (head_pop),
    .rp        (rp),
    .oq_full   (oq_full)
  );

  // result queue
  slint_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .rp      (rp),
    .oq_full (oq_full),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  // the walk never pushes into a full result queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    rp.push |-> !oq_full)
    else $error("result pushed into full queue");

  // an empty intersection carries a zero element and closes the job
  a_empty_res_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.empty_res) |-> (res.element == '0 && res.last && !res.found))
    else $error("malformed empty result");

  // a found report is a single zero-element result
  a_found_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.found) |-> (res.element == '0 && res.last && !res.empty_res))
    else $error("malformed existence result");

  // after reset the result side is empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("results present after reset");

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: sorted list intersection unit
// Loads pairs of ascending lists, starts merge jobs in both report modes and
// checks every result request against a cycle-free predictor of the merge.
// The sender and receiver idle at random in several phases. A long receiver
// hold-off fills the unit so that it stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import slint_pkg::*;

  // unused command code, ignored by the unit
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 400;

  typedef logic [31:0] word_q_t[$];

  // dut ports
  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic push      = 1'b0;
  logic full;
  req_t req       = '0;
  logic empty;
  logic pop       = 1'b0;
  res_t res;
  logic cfg_we    = 1'b0;
  logic cfg_wdata = 1'b0;

  // predictor state
  logic [31:0] shadow_a [DEPTH];
  logic [31:0] shadow_b [DEPTH];
  int          shadow_cnt_a = 0;
  int          shadow_cnt_b = 0;
  bit          shadow_ovf   = 1'b0;
  bit          exist_mode   = 1'b0;
  res_t        due_results[$];

  // run control and bookkeeping
  int tx_gap_pct   = 0;
  int rx_stall_pct = 0;
  bit hold_req     = 1'b0;
  logic hold_active = 1'b0;
  int fail_count   = 0;
  int items_sent   = 0;
  int n_jobs       = 0;
  int n_ovf_jobs   = 0;
  int n_shared     = 0;
  int n_results    = 0;
  int n_found      = 0;
  int n_cfg_writes = 0;
  int cycle_count  = 0;
  int full_cycles  = 0;

  sorted_list_intersection_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .empty     (empty),
    .pop       (pop),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic req_t make_req(logic [1:0] cmd, logic [31:0] value, logic same);
    req_t r;
    r.cmd       = cmd;
    r.value     = value;
    r.same_list = same;
    return r;
  endfunction

  function automatic res_t make_result(logic [31:0] elem, logic empty_res, logic found,
                                       logic ovf, logic last);
    res_t r;
    r.element   = elem;
    r.empty_res = empty_res;
    r.found     = found;
    r.overflow  = ovf;
    r.last      = last;
    return r;
  endfunction

  // merge walk predictor: updates list state, queues the results of a start
  task automatic predict_merge(input req_t r);
    int i;
    int j;
    bit hit;
    logic [31:0] hits[$];
    case (r.cmd)
      CMD_LOAD_A: begin
        if (shadow_cnt_a < DEPTH) begin
          shadow_a[shadow_cnt_a] = r.value;
          shadow_cnt_a++;
        end else begin
          shadow_ovf = 1'b1;
        end
      end
      CMD_LOAD_B: begin
        if (shadow_cnt_b < DEPTH) begin
          shadow_b[shadow_cnt_b] = r.value;
          shadow_cnt_b++;
        end else begin
          shadow_ovf = 1'b1;
        end
      end
      CMD_START: begin
        i = 0;
        j = 0;
        hit = 1'b0;
        if (exist_mode) begin
          // stop at the first common element
          while (i < shadow_cnt_a && j < shadow_cnt_b && !hit) begin
            if (shadow_a[i] == shadow_b[j]) hit = 1'b1;
            else if (shadow_a[i] < shadow_b[j]) i++;
            else j++;
          end
          due_results.push_back(make_result('0, 1'b0, hit, shadow_ovf, 1'b1));
        end else begin
          if (r.same_list) begin
            for (i = 0; i < shadow_cnt_a; i++) hits.push_back(shadow_a[i]);
          end else begin
            while (i < shadow_cnt_a && j < shadow_cnt_b) begin
              if (shadow_a[i] == shadow_b[j]) begin
                hits.push_back(shadow_a[i]);
                i++;
                j++;
              end else if (shadow_a[i] < shadow_b[j]) begin
                i++;
              end else begin
                j++;
              end
            end
          end
          if (hits.size() == 0) begin
            due_results.push_back(make_result('0, 1'b1, 1'b0, shadow_ovf, 1'b1));
          end else begin
            foreach (hits[k])
              due_results.push_back(make_result(hits[k], 1'b0, 1'b0, shadow_ovf,
                                                k == hits.size() - 1));
          end
        end
        shadow_cnt_a = 0;
        shadow_cnt_b = 0;
        shadow_ovf   = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fail_count++;
  endtask

  // result checker
  always @(posedge clk) begin : res_check
    res_t want;
    if (!rst && pop && !empty) begin
      n_results++;
      if (res.found) n_found++;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected result element", res.element, '0);
      end else begin
        want = due_results.pop_front();
        if (res.element !== want.element)
          report_mismatch("element", res.element, want.element);
        if (res.empty_res !== want.empty_res)
          report_mismatch("empty_res", res.empty_res, want.empty_res);
        if (res.found !== want.found)
          report_mismatch("found", res.found, want.found);
        if (res.overflow !== want.overflow)
          report_mismatch("overflow", res.overflow, want.overflow);
        if (res.last !== want.last)
          report_mismatch("last", res.last, want.last);
      end
    end
  end

  // receiver: random stalls, or held off completely
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else if (hold_active) pop <= 1'b0;
    else pop <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // long receiver hold-off, counted here
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
      end
    end
  end

  // watchdog and input stall counter
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (push && full) full_cycles <= full_cycles + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               due_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // send one request, with random idle cycles ahead of it
  task automatic send_request(input req_t r);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    req  <= r;
    do @(posedge clk); while (full);
    predict_merge(r);
    if (r.cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic wait_results_done();
    push <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_results_done();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_report_mode(input bit m);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we    <= 1'b0;
    exist_mode = m;
    n_cfg_writes++;
  endtask

  // load both lists in random interleave, then start
  task automatic send_job(input word_q_t a, input word_q_t b, input bit same,
                          input bit noise);
    int ia;
    int ib;
    ia = 0;
    ib = 0;
    while (ia < a.size() || ib < b.size()) begin
      if (noise && $urandom_range(0, 19) == 0)
        send_request(make_req(CMD_UNUSED, $urandom, $urandom_range(0, 1)));
      if (ib >= b.size() || (ia < a.size() && $urandom_range(0, 1) == 1)) begin
        send_request(make_req(CMD_LOAD_A, a[ia], $urandom_range(0, 1)));
        ia++;
      end else begin
        send_request(make_req(CMD_LOAD_B, b[ib], $urandom_range(0, 1)));
        ib++;
      end
    end
    send_request(make_req(CMD_START, $urandom, same));
    n_jobs++;
    if (same) n_shared++;
    if (a.size() > DEPTH || b.size() > DEPTH) n_ovf_jobs++;
  endtask

  // intersect mode: empty lists, value extremes, unused command, shared list
  task automatic test_directed_intersect();
    word_q_t none;
    word_q_t a;
    word_q_t b;
    write_report_mode(1'b0);
    send_job(none, none, 1'b0, 1'b0);
    a = '{32'h0, 32'h5, 32'hFFFFFFFF};
    b = '{32'h0, 32'h7, 32'hFFFFFFFF};
    send_job(a, b, 1'b0, 1'b0);
    send_request(make_req(CMD_UNUSED, 32'hFFFFFFFF, 1'b1));
    a = '{32'h3, 32'h9};
    send_job(a, none, 1'b1, 1'b0);
    b = '{32'h4};
    send_job(none, b, 1'b1, 1'b0);
    a = '{32'h1, 32'h2};
    b = '{32'h3};
    send_job(a, b, 1'b0, 1'b0);
    wait_idle();
  endtask

  // existence mode: hit, miss, shared flag ignored
  task automatic test_directed_existence();
    word_q_t none;
    word_q_t a;
    word_q_t b;
    write_report_mode(1'b1);
    a = '{32'h1, 32'h2};
    b = '{32'h2};
    send_job(a, b, 1'b0, 1'b0);
    a = '{32'h1};
    b = '{32'h2};
    send_job(a, b, 1'b1, 1'b0);
    send_job(none, none, 1'b1, 1'b0);
    write_report_mode(1'b0);
  endtask

  // more loads than a list holds, in both lists
  task automatic test_overflow();
    word_q_t a;
    word_q_t b;
    for (int k = 0; k < DEPTH + 2; k++) a.push_back(k * 3);
    for (int k = 0; k < DEPTH; k++) b.push_back(k * 2);
    send_job(a, b, 1'b0, 1'b0);
    a.delete();
    b.delete();
    for (int k = 0; k < DEPTH + 1; k++) b.push_back(32'hFFFFFF00 + k);
    send_job(a, b, 1'b0, 1'b0);
    wait_idle();
  endtask

  // receiver held off while long jobs and more requests keep coming
  task automatic test_backpressure();
    word_q_t a;
    word_q_t b;
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_req     = 1'b1;
    for (int k = 0; k < 20; k++) a.push_back(100 + k);
    send_job(a, a, 1'b0, 1'b0);
    b = '{32'd101, 32'd110, 32'd119};
    send_job(a, b, 1'b0, 1'b0);
    send_job(b, b, 1'b1, 1'b0);
    // sender pauses until every result is back
    wait_results_done();
    send_job(b, a, 1'b0, 1'b0);
    wait_idle();
  endtask

  // one random job: mostly sorted lists with overlap, some overflow and noise
  task automatic run_random_job();
    word_q_t a;
    word_q_t b;
    int la;
    int lb;
    int step_max;
    int place;
    logic [63:0] cur;
    bit same;
    bit scramble;
    la = ($urandom_range(0, 7) == 0) ? $urandom_range(0, DEPTH) : $urandom_range(0, 10);
    lb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, DEPTH) : $urandom_range(0, 10);
    if ($urandom_range(0, 11) == 0) la = DEPTH + $urandom_range(1, 3);
    if ($urandom_range(0, 11) == 0) lb = DEPTH + $urandom_range(1, 3);
    same     = ($urandom_range(0, 5) == 0);
    scramble = ($urandom_range(0, 11) == 0);
    case ($urandom_range(0, 3))
      0: step_max = 3;
      1: step_max = 1000;
      2: step_max = 1 << 26;
      default: step_max = 20;
    endcase
    case ($urandom_range(0, 5))
      0: cur = 64'h0;
      1: cur = 64'hFFFFFF00;
      default: cur = {32'h0, $urandom >> $urandom_range(0, 31)};
    endcase
    while (a.size() < la || b.size() < lb) begin
      if (scramble) begin
        // unsorted lists, small values so that the walk still meets
        if (a.size() < la) a.push_back($urandom_range(0, 15));
        if (b.size() < lb) b.push_back($urandom_range(0, 15));
      end else begin
        cur = cur + $urandom_range(0, step_max);
        if (cur > 64'hFFFFFFFF) cur = 64'hFFFFFFFF;
        place = $urandom_range(0, 2);
        if (a.size() >= la) place = 1;
        else if (b.size() >= lb) place = 0;
        if (place != 1) a.push_back(cur[31:0]);
        if (place != 0) b.push_back(cur[31:0]);
      end
    end
    send_job(a, b, same, 1'b1);
  endtask

  task automatic test_random(input int gap_pct, input int stall_pct, input int items);
    int target;
    tx_gap_pct   = gap_pct;
    rx_stall_pct = stall_pct;
    target = items_sent + items;
    while (items_sent < target) begin
      if ($urandom_range(0, 3) == 0) write_report_mode($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) wait_results_done();
      run_random_job();
    end
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_intersect();
    test_directed_existence();
    test_overflow();
    test_backpressure();
    test_random(0, 0, 45);
    test_random(46, 0, 45);
    test_random(0, 46, 45);
    test_random(9, 9, 45);

    // trailing drain, then look for leftovers
    wait_results_done();
    repeat (4 * DRAIN_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch("results never delivered", due_results.size(), 0);

    $display("covered %0d jobs, %0d shared-list, %0d with dropped loads; %0d requests",
             n_jobs, n_shared, n_ovf_jobs, items_sent);
    $display("%0d results checked (%0d found), %0d mode writes, %0d input stall cycles",
             n_results, n_found, n_cfg_writes, full_cycles);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sorted_list_intersection_unit.f
rtl/slint_pkg.sv
rtl/slint_front.sv
rtl/slint_back.sv
rtl/slint_outq.sv
rtl/sorted_list_intersection_unit.sv
tb/sv/testbench.sv
